FILE: rtl/flxseg_pkg.sv
package flxseg_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_MIN_GAP_LEN = 2'd0;
    localparam logic [1:0] CFG_TRACK1_MASK = 2'd1;
    localparam logic [1:0] CFG_TRACK2_MASK = 2'd2;

    localparam int unsigned GROUP_SLOTS = 3;

    typedef enum logic [1:0] {
        KIND_INTERVAL     = 2'd0,
        KIND_CHUNK_END    = 2'd1,
        KIND_TRAILING_GAP = 2'd2
    } rec_kind_t;

    typedef struct packed {
        logic [7:0] sample;
        logic       end_of_capture;
    } sample_beat_t;

    typedef struct packed {
        rec_kind_t   kind;
        logic        track1_valid;
        logic [31:0] track1_interval;
        logic        track2_valid;
        logic [31:0] track2_interval;
        logic [31:0] gap_len;
        logic [31:0] data_len;
        logic        last_of_run;
    } rec_beat_t;

    typedef struct packed {
        logic [31:0] min_gap_len;
        logic [7:0]  track1_mask;
        logic [7:0]  track2_mask;
    } cfg_t;

    // slot 0: transition record, slot 1: flushed chunk end, slot 2: trailing gap
    typedef struct packed {
        logic [GROUP_SLOTS-1:0]            mask;
        rec_beat_t [GROUP_SLOTS-1:0]       recs;
    } rec_group_t;

endpackage

FILE: rtl/flxseg_engine.sv
module flxseg_engine #(
    parameter int POS_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     fire,
    input  flxseg_pkg::sample_beat_t item,
    input  flxseg_pkg::cfg_t         cfg,
    output flxseg_pkg::rec_group_t   group
);

    localparam int XW = (POS_WIDTH > 32) ? POS_WIDTH : 33;

    function automatic logic [XW-1:0] ext(input logic [POS_WIDTH-1:0] p);
        return XW'(p);
    endfunction

    function automatic logic [31:0] sat32(input logic [XW-1:0] v);
        if (v > XW'(32'hFFFF_FFFF))
            return 32'hFFFF_FFFF;
        else
            return v[31:0];
    endfunction

    function automatic logic [POS_WIDTH-1:0] diff(input logic [POS_WIDTH-1:0] a,
                                                  input logic [POS_WIDTH-1:0] b);
        return (a >= b) ? a - b : '0;
    endfunction

    logic [POS_WIDTH-1:0] pos_reg,         pos_next;
    logic [7:0]           prev_reg,        prev_next;
    logic                 seen_reg,        seen_next;
    logic                 first_pend_reg,  first_pend_next;
    logic [POS_WIDTH-1:0] last_tr_reg,     last_tr_next;
    logic [POS_WIDTH-1:0] last_t1_reg,     last_t1_next;
    logic [POS_WIDTH-1:0] last_t2_reg,     last_t2_next;
    logic [POS_WIDTH-1:0] chunk_start_reg, chunk_start_next;
    logic [31:0]          gap_acc_reg,     gap_acc_next;
    logic                 has_int_reg,     has_int_next;

    logic [7:0]           prev_eff;
    logic [7:0]           trig;
    logic [POS_WIDTH-1:0] since;
    logic [POS_WIDTH-1:0] size;
    logic [POS_WIDTH-1:0] tail;
    logic                 new_chunk;
    logic [31:0]          gap_base;
    logic [32:0]          gap_sum;

    always_comb
    begin
        pos_next         = pos_reg;
        prev_next        = item.sample;
        seen_next        = 1'b1;
        first_pend_next  = first_pend_reg;
        last_tr_next     = last_tr_reg;
        last_t1_next     = last_t1_reg;
        last_t2_next     = last_t2_reg;
        chunk_start_next = chunk_start_reg;
        gap_acc_next     = gap_acc_reg;
        has_int_next     = has_int_reg;
        group            = '0;

        prev_eff  = seen_reg ? prev_reg : item.sample;
        trig      = (item.sample ^ prev_eff) & (cfg.track1_mask | cfg.track2_mask);
        since     = diff(pos_reg, last_tr_reg);
        new_chunk = first_pend_reg || (ext(since) >= XW'(cfg.min_gap_len));
        gap_base  = has_int_reg ? 32'd0 : gap_acc_reg;
        gap_sum   = {1'b0, gap_base} + {1'b0, sat32(ext(since))};

        if (trig != 8'd0)
        begin
            if (new_chunk)
            begin
                if (has_int_reg)
                begin
                    group.mask[0]          = 1'b1;
                    group.recs[0].kind     = flxseg_pkg::KIND_CHUNK_END;
                    group.recs[0].gap_len  = gap_acc_reg;
                    group.recs[0].data_len = sat32(ext(diff(last_tr_reg, chunk_start_reg)));
                end
                gap_acc_next     = gap_sum[32] ? 32'hFFFF_FFFF : gap_sum[31:0];
                chunk_start_next = pos_reg;
                last_tr_next     = pos_reg;
                last_t1_next     = pos_reg;
                last_t2_next     = pos_reg;
                has_int_next     = 1'b0;
                first_pend_next  = 1'b0;
            end
            else
            begin
                group.mask[0]      = 1'b1;
                group.recs[0].kind = flxseg_pkg::KIND_INTERVAL;
                last_tr_next       = pos_reg;
                if ((trig & cfg.track1_mask) != 8'd0)
                begin
                    group.recs[0].track1_valid    = 1'b1;
                    group.recs[0].track1_interval = sat32(ext(diff(pos_reg, last_t1_reg)));
                    last_t1_next                  = pos_reg;
                end
                if ((trig & cfg.track2_mask) != 8'd0)
                begin
                    group.recs[0].track2_valid    = 1'b1;
                    group.recs[0].track2_interval = sat32(ext(diff(pos_reg, last_t2_reg)));
                    last_t2_next                  = pos_reg;
                end
                has_int_next = 1'b1;
            end
        end

        size = (&pos_reg) ? pos_reg : pos_reg + 1'b1;
        tail = diff(size, last_tr_next);

        if (item.end_of_capture)
        begin
            if (has_int_next)
            begin
                group.mask[1]          = 1'b1;
                group.recs[1].kind     = flxseg_pkg::KIND_CHUNK_END;
                group.recs[1].gap_len  = gap_acc_next;
                group.recs[1].data_len = sat32(ext(diff(size, chunk_start_next)));
            end
            if (ext(tail) >= XW'(cfg.min_gap_len))
            begin
                group.mask[2]         = 1'b1;
                group.recs[2].kind    = flxseg_pkg::KIND_TRAILING_GAP;
                group.recs[2].gap_len = sat32(ext(tail));
            end
            // capture done: back to the post-reset state
            pos_next         = '0;
            prev_next        = 8'd0;
            seen_next        = 1'b0;
            first_pend_next  = 1'b1;
            last_tr_next     = '0;
            last_t1_next     = '0;
            last_t2_next     = '0;
            chunk_start_next = '0;
            gap_acc_next     = 32'd0;
            has_int_next     = 1'b0;
        end
        else
        begin
            pos_next = size;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg         <= '0;
            prev_reg        <= 8'd0;
            seen_reg        <= 1'b0;
            first_pend_reg  <= 1'b1;
            last_tr_reg     <= '0;
            last_t1_reg     <= '0;
            last_t2_reg     <= '0;
            chunk_start_reg <= '0;
            gap_acc_reg     <= 32'd0;
            has_int_reg     <= 1'b0;
        end
        else if (fire)
        begin
            pos_reg         <= pos_next;
            prev_reg        <= prev_next;
            seen_reg        <= seen_next;
            first_pend_reg  <= first_pend_next;
            last_tr_reg     <= last_tr_next;
            last_t1_reg     <= last_t1_next;
            last_t2_reg     <= last_t2_next;
            chunk_start_reg <= chunk_start_next;
            gap_acc_reg     <= gap_acc_next;
            has_int_reg     <= has_int_next;
        end
    end

endmodule

FILE: rtl/flux_interval_segmenter.sv
// Timing: an accepted sample beat waits in the input register until the result
//   group register is free; the engine then processes it and offers its results.
// Throughput: one sample beat per cycle with at most one result per sample and no sink
//   stall; a sample with more results holds the result register until all are taken.
// Reset (rst_n, async, active low): tracking state cleared, registers back to
//   min_gap_len 1000, track1_mask 1, track2_mask 2; both stages empty.
module flux_interval_segmenter #(
    parameter int POS_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    // sample channel
    input  logic                     sample_valid,
    output logic                     sample_stall,
    input  flxseg_pkg::sample_beat_t sample_beat,
    // result channel
    output logic                     rec_valid,
    input  logic                     rec_stall,
    output flxseg_pkg::rec_beat_t    rec_beat,
    // register writes
    input  logic                     cfg_write,
    input  logic [1:0]               cfg_index,
    input  logic [31:0]              cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    flxseg_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.min_gap_len <= 32'd1000;
            cfg_reg.track1_mask <= 8'd1;
            cfg_reg.track2_mask <= 8'd2;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                flxseg_pkg::CFG_MIN_GAP_LEN: cfg_reg.min_gap_len <= cfg_data;
                flxseg_pkg::CFG_TRACK1_MASK: cfg_reg.track1_mask <= cfg_data[7:0];
                flxseg_pkg::CFG_TRACK2_MASK: cfg_reg.track2_mask <= cfg_data[7:0];
                default: ;  // unmapped index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register. It takes beats while empty or while the item it holds
    // can move into the result group register this cycle.
    // ------------------------------------------------------------------
    logic                     in_vld_reg;
    flxseg_pkg::sample_beat_t in_data_reg;
    logic                     advance;
    logic                     sample_take;

    assign sample_stall = in_vld_reg && !advance;
    assign sample_take  = sample_valid && !sample_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_vld_reg <= 1'b0;
        else if (sample_take)
            in_vld_reg <= 1'b1;
        else if (advance)
            in_vld_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (sample_take)
            in_data_reg <= sample_beat;
    end

    // ------------------------------------------------------------------
    // Segmenting logic: state lives in the engine, which updates on advance
    // and hands back up to three result records for the item.
    // ------------------------------------------------------------------
    flxseg_pkg::rec_group_t eng_group;

    flxseg_engine #(
        .POS_WIDTH (POS_WIDTH)
    ) u_engine (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (advance),
        .item  (in_data_reg),
        .cfg   (cfg_reg),
        .group (eng_group)
    );

    // ------------------------------------------------------------------
    // Result group register. Slots drain lowest first, one beat a cycle without rec_stall.
    // ------------------------------------------------------------------
    logic [flxseg_pkg::GROUP_SLOTS-1:0]      grp_vld_reg, grp_vld_next;
    flxseg_pkg::rec_beat_t [flxseg_pkg::GROUP_SLOTS-1:0] grp_rec_reg;
    logic [flxseg_pkg::GROUP_SLOTS-1:0]      sel;
    logic [flxseg_pkg::GROUP_SLOTS-1:0]      remain;
    logic                                    rec_take;
    logic                                    grp_free;

    always_comb
    begin
        if (grp_vld_reg[0])
            sel = 3'b001;
        else if (grp_vld_reg[1])
            sel = 3'b010;
        else if (grp_vld_reg[2])
            sel = 3'b100;
        else
            sel = 3'b000;
    end

    assign remain    = grp_vld_reg & ~sel;
    assign rec_valid = |grp_vld_reg;
    assign rec_take  = rec_valid && !rec_stall;
    // group empty, or its last beat leaves this cycle
    assign grp_free  = !rec_valid || (rec_take && (remain == '0));
    assign advance   = in_vld_reg && grp_free;

    always_comb
    begin
        rec_beat = grp_rec_reg[2];
        if (sel[0])
            rec_beat = grp_rec_reg[0];
        else if (sel[1])
            rec_beat = grp_rec_reg[1];
        rec_beat.last_of_run = (remain == '0);
    end

    always_comb
    begin
        if (advance)
            grp_vld_next = eng_group.mask;
        else if (rec_take)
            grp_vld_next = remain;
        else
            grp_vld_next = grp_vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            grp_vld_reg <= '0;
        else
            grp_vld_reg <= grp_vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            grp_rec_reg <= eng_group.recs;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // the engine only fires when the held group is gone or leaving
    a_advance_free: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> (!rec_valid || (rec_take && rec_beat.last_of_run)))
        else $error("group overwritten while beats still pending");

    // an interval record always carries at least one track interval
    a_interval_track: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_beat.kind == flxseg_pkg::KIND_INTERVAL)
            |-> (rec_beat.track1_valid || rec_beat.track2_valid))
        else $error("interval record with no track");

    // chunk end and trailing gap records carry no track intervals
    a_marker_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_beat.kind != flxseg_pkg::KIND_INTERVAL)
            |-> (!rec_beat.track1_valid && !rec_beat.track2_valid
                 && rec_beat.track1_interval == 32'd0
                 && rec_beat.track2_interval == 32'd0))
        else $error("marker record with track data");

    // a trailing gap is always the final beat of its sample
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && rec_beat.kind == flxseg_pkg::KIND_TRAILING_GAP)
            |-> rec_beat.last_of_run)
        else $error("trailing gap not last of run");

endmodule
